FILE: sv/sfsc_pkg.sv
package sfsc_pkg;

	localparam int LINES_DEF    = 2;
	localparam int BODY_MAX_DEF = 256;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;

	localparam logic REG_HEADER_FIRST  = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	localparam logic FUNC_FEED = 1'b0;

	localparam logic [7:0] ADDR_SRC_A = 8'h20;
	localparam logic [7:0] ADDR_SRC_B = 8'h21;
	localparam logic [7:0] ADDR_SRC_C = 8'h22;
	localparam logic [7:0] ADDR_SRC_D = 8'h3E;
	localparam logic [7:0] ADDR_SRC_E = 8'h3F;

	localparam logic [1:0] KIND_IDLE     = 2'd0;
	localparam logic [1:0] KIND_NOISE    = 2'd1;
	localparam logic [1:0] KIND_PROTOCOL = 2'd2;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_GOOD = 2'd1;
	localparam logic [1:0] EV_BAD  = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [8:0]  pos;
		logic [7:0]  len;
		logic [15:0] sum;
		logic [31:0] bytes;
		logic [31:0] good;
		logic [31:0] bad;
		logic [5:0]  seen;
		logic [7:0]  prev_src;
		logic [7:0]  prev_dst;
	} line_t;

	typedef struct packed {
		logic [7:0] ck_lo;
		logic [7:0] src;
		logic [7:0] dst;
	} held_t;

	localparam line_t LINE_INIT = '{
		phase:    PH_HUNT,
		pos:      9'd0,
		len:      8'd0,
		sum:      16'd0,
		bytes:    32'd0,
		good:     32'd0,
		bad:      32'd0,
		seen:     6'd0,
		prev_src: 8'd0,
		prev_dst: 8'd0
	};

	function automatic logic [5:0] source_bit(input logic [7:0] a);
		logic [5:0] r;
		unique case (a)
			ADDR_SRC_A: r = 6'b000001;
			ADDR_SRC_B: r = 6'b000010;
			ADDR_SRC_C: r = 6'b000100;
			ADDR_SRC_D: r = 6'b001000;
			ADDR_SRC_E: r = 6'b010000;
			default:    r = 6'b100000;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/serial_frame_sniffer_classifier.sv
// Passive frame sniffer for several serial lines.
// Input channel: in_valid/in_stall carries one beat per item: func, line_select
// and data_byte. A feed beat advances the frame parser of the chosen line; a
// status beat only reads that line. Each beat gives exactly one result beat on
// the output channel out_valid/out_stall with the line's counters, address mask,
// last good source and destination, and the frame event caused by the beat.
// A beat accepted into the input register is parsed once the output register
// is free, and its result is loaded into that register. One beat per cycle is
// sustained while the receiver does not stall, also on the same line, since the
// line state is updated in the same cycle as the result register is loaded.
// When the receiver stalls, the result register holds and one more beat waits
// in the input register; after that in_stall rises until the result is taken.
// Reset clears all counters, parsers and masks of every line and loads the
// default header bytes 0x5A and 0xA5. The user must write the header registers
// (cfg_wr_en, cfg_index, cfg_data) only while idle; not enforced by the block.
module serial_frame_sniffer_classifier
	import sfsc_pkg::*;
#(
	parameter int LINES    = LINES_DEF,
	parameter int BODY_MAX = BODY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic        line_select,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  line_kind,
	output logic [31:0] byte_total,
	output logic [31:0] good_total,
	output logic [31:0] bad_total,
	output logic [15:0] address_seen,
	output logic [7:0]  recent_source,
	output logic [7:0]  recent_dest,
	output logic [1:0]  frame_event
);

	localparam int LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;

	logic [7:0] header_first_q;
	logic [7:0] header_second_q;

	logic       valid_s1;
	logic       func_s1;
	logic       line_s1;
	logic [7:0] byte_s1;

	line_t st_q [LINES];
	held_t hd_q [LINES];

	logic              advance;
	logic              in_range;
	logic              feed;
	logic [LIDX_W-1:0] idx;
	line_t             cur;
	line_t             nxt;
	held_t             hcur;
	held_t             hnxt;
	logic [1:0]        ev;
	logic [7:0]        len_eff;
	logic [8:0]        lim5;
	logic [9:0]        lim7;
	logic [9:0]        pos_inc;
	logic [15:0]       calc;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] bytes_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic [15:0] mask_q;
	logic [7:0]  src_q;
	logic [7:0]  dst_q;
	logic [1:0]  ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				REG_HEADER_SECOND: header_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			line_s1 <= line_select;
			byte_s1 <= data_byte;
		end
	end

	assign in_range = (32'(line_s1) < LINES);
	assign idx      = in_range ? LIDX_W'(line_s1) : '0;
	assign feed     = in_range && (func_s1 == FUNC_FEED);
	assign cur      = st_q[idx];
	assign hcur     = hd_q[idx];

	always_comb begin
		nxt     = cur;
		hnxt    = hcur;
		ev      = EV_NONE;
		len_eff = cur.len;
		lim5    = '0;
		lim7    = '0;
		pos_inc = '0;
		calc    = ~cur.sum;
		if (feed) begin
			nxt.bytes = cur.bytes + 32'd1;
			unique case (cur.phase)
				PH_HUNT: begin
					if (byte_s1 == header_first_q) begin
						nxt.phase = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (byte_s1 == header_second_q) begin
						nxt.phase = PH_BODY;
						nxt.pos   = '0;
						nxt.sum   = '0;
					end else if (byte_s1 != header_first_q) begin
						nxt.phase = PH_HUNT;
					end
				end
				PH_BODY: begin
					if (cur.pos == 9'd0) begin
						len_eff = byte_s1;
						nxt.len = byte_s1;
					end
					lim5    = {1'b0, len_eff} + 9'd5;
					lim7    = {2'b00, len_eff} + 10'd7;
					pos_inc = {1'b0, cur.pos} + 10'd1;
					if ((cur.pos == 9'd0) && (({2'b00, byte_s1} + 10'd7) > 10'(BODY_MAX))) begin
						nxt.phase = PH_HUNT;
					end else begin
						if (cur.pos == 9'd1) begin
							hnxt.src = byte_s1;
						end
						if (cur.pos == 9'd2) begin
							hnxt.dst = byte_s1;
						end
						if (cur.pos < lim5) begin
							nxt.sum = cur.sum + {8'd0, byte_s1};
						end else if (cur.pos == lim5) begin
							hnxt.ck_lo = byte_s1;
						end
						nxt.pos = pos_inc[8:0];
						if (pos_inc >= lim7) begin
							nxt.phase = PH_HUNT;
							if (calc != {byte_s1, hcur.ck_lo}) begin
								nxt.bad = cur.bad + 32'd1;
								ev      = EV_BAD;
							end else begin
								nxt.good     = cur.good + 32'd1;
								nxt.prev_src = hcur.src;
								nxt.prev_dst = hcur.dst;
								nxt.seen     = cur.seen | source_bit(hcur.src);
								ev           = EV_GOOD;
							end
						end
					end
				end
				default: begin
					nxt.phase = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				st_q[i] <= LINE_INIT;
			end
		end else if (advance && feed) begin
			st_q[idx] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && feed) begin
			hd_q[idx] <= hnxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_range) begin
				if (nxt.good != 32'd0) begin
					kind_q <= KIND_PROTOCOL;
				end else if (nxt.bytes != 32'd0) begin
					kind_q <= KIND_NOISE;
				end else begin
					kind_q <= KIND_IDLE;
				end
				bytes_q <= nxt.bytes;
				good_q  <= nxt.good;
				bad_q   <= nxt.bad;
				mask_q  <= {nxt.seen[5], 10'd0, nxt.seen[4:0]};
				src_q   <= nxt.prev_src;
				dst_q   <= nxt.prev_dst;
				ev_q    <= ev;
			end else begin
				kind_q  <= KIND_IDLE;
				bytes_q <= '0;
				good_q  <= '0;
				bad_q   <= '0;
				mask_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				ev_q    <= EV_NONE;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign line_kind     = kind_q;
	assign byte_total    = bytes_q;
	assign good_total    = good_q;
	assign bad_total     = bad_q;
	assign address_seen  = mask_q;
	assign recent_source = src_q;
	assign recent_dest   = dst_q;
	assign frame_event   = ev_q;

endmodule
